// ===== rtl/core/cdeq_pkg.sv =====
// Shared types and codes for the circular double-ended queue.
package cdeq_pkg;

    localparam int WORD_W   = 32;
    localparam int MODE_W   = 2;
    localparam int STATUS_W = 2;

    typedef logic signed [WORD_W-1:0] word_t;
    typedef logic [MODE_W-1:0]        mode_t;
    typedef logic [STATUS_W-1:0]      status_t;

    // Operation codes carried on the mode field.
    localparam mode_t MODE_PUSH_LEFT  = 2'd0;
    localparam mode_t MODE_POP_LEFT   = 2'd1;
    localparam mode_t MODE_PUSH_RIGHT = 2'd2;
    localparam mode_t MODE_POP_RIGHT  = 2'd3;

    // Result status codes.
    localparam status_t STATUS_DONE  = 2'd0;
    localparam status_t STATUS_FULL  = 2'd1;
    localparam status_t STATUS_EMPTY = 2'd2;

endpackage

// ===== rtl/core/cdeq_mem.sv =====
// Word store of the queue: one write port and one registered read port.
module cdeq_mem #(
    parameter int DEPTH = 16,
    parameter int IDX_W = 4
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [IDX_W-1:0]  wr_addr,
    input  cdeq_pkg::word_t   wr_data,
    input  logic              rd_en,
    input  logic [IDX_W-1:0]  rd_addr,
    output cdeq_pkg::word_t   rd_data
);

    cdeq_pkg::word_t mem_array [DEPTH];
    cdeq_pkg::word_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_array[wr_addr] <= wr_data;
        end
    end

    // The read data is registered, so it appears in the cycle after the address.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_array[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/circular_double_ended_queue_core.sv =====
// Top level of the circular double-ended queue of signed 32-bit words.
// Usage: each input beat on the in channel (in_valid / in_stall) carries one
// operation in mode (push left, pop left, push right, pop right) and, for
// pushes, the word in push_word. Each accepted beat produces exactly one
// result beat on the out channel (out_valid / out_stall) with the status,
// the count after the operation, empty and full flags, and the words at
// both ends (zero when the queue is empty).
// Sequencing: a push, a refused operation and a pop that empties the queue
// load the result register directly, and the next beat may be accepted in
// the following cycle unless a waiting result is stalled. A pop that leaves
// words behind goes through the fetch state, because the new end word must
// be fetched from the synchronous word store, whose read data arrives in the
// cycle after the address; the block stalls its input during that fetch. The
// words at both ends are kept in registers, so a push never needs a read.
// Reset: rst_n clears the indexes, the count and the output valid. The word
// store is not cleared and needs no clearing pass, as only written entries
// are ever read.
// Back-pressure: the result sits in an output register. A new beat is still
// accepted while that register drains in the same cycle; while the receiver
// stalls a waiting result, in_stall is held high and the result is held.
module circular_double_ended_queue_core #(
    parameter int DEPTH = 16,
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  cdeq_pkg::mode_t            mode,
    input  cdeq_pkg::word_t            push_word,
    output logic                       out_valid,
    input  logic                       out_stall,
    output cdeq_pkg::status_t          status,
    output logic [CNT_W-1:0]           count,
    output logic                       is_empty,
    output logic                       is_full,
    output cdeq_pkg::word_t            front_word,
    output cdeq_pkg::word_t            back_word
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
    localparam logic [IDX_W-1:0] ZERO_IDX = '0;
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] ZERO_CNT = '0;
    localparam logic [CNT_W-1:0] ONE_CNT  = CNT_W'(1);

    // Sequencer states: taking beats, or waiting for an end word from the store.
    localparam logic S_IDLE  = 1'b0;
    localparam logic S_FETCH = 1'b1;

    logic                 state_reg, state_next;
    logic [IDX_W-1:0]     left_reg, left_next;
    logic [IDX_W-1:0]     right_reg, right_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    cdeq_pkg::word_t      front_reg, front_next;
    cdeq_pkg::word_t      back_reg, back_next;
    logic                 pend_left_reg, pend_left_next;

    logic                 out_valid_reg, out_valid_next;
    cdeq_pkg::status_t    status_out_reg, status_out_next;
    logic [CNT_W-1:0]     count_out_reg, count_out_next;
    cdeq_pkg::word_t      front_out_reg, front_out_next;
    cdeq_pkg::word_t      back_out_reg, back_out_next;

    logic                 accept;
    logic                 is_push;
    logic                 is_left;
    logic                 q_empty;
    logic                 q_full;
    logic                 load_out;
    cdeq_pkg::status_t    status_now;
    logic [IDX_W-1:0]     left_out_idx, left_in_idx;
    logic [IDX_W-1:0]     right_out_idx, right_in_idx;

    logic                 mem_wr_en;
    logic [IDX_W-1:0]     mem_wr_addr;
    logic                 mem_rd_en;
    logic [IDX_W-1:0]     mem_rd_addr;
    cdeq_pkg::word_t      mem_rd_data;

    cdeq_mem #(
        .DEPTH (DEPTH),
        .IDX_W (IDX_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (push_word),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // The input is held off during a fetch and while a result waits stalled.
    assign in_stall = (state_reg == S_FETCH) || (out_valid_reg && out_stall);
    assign accept   = in_valid && !in_stall;

    assign is_push = (mode == cdeq_pkg::MODE_PUSH_LEFT) || (mode == cdeq_pkg::MODE_PUSH_RIGHT);
    assign is_left = (mode == cdeq_pkg::MODE_PUSH_LEFT) || (mode == cdeq_pkg::MODE_POP_LEFT);
    assign q_empty = (count_reg == ZERO_CNT);
    assign q_full  = (count_reg == FULL_CNT);

    // Neighbouring slots with wrap-round; the depth need not be a power of two.
    assign left_out_idx  = (left_reg == ZERO_IDX) ? LAST_IDX : left_reg - 1'b1;
    assign left_in_idx   = (left_reg == LAST_IDX) ? ZERO_IDX : left_reg + 1'b1;
    assign right_out_idx = (right_reg == LAST_IDX) ? ZERO_IDX : right_reg + 1'b1;
    assign right_in_idx  = (right_reg == ZERO_IDX) ? LAST_IDX : right_reg - 1'b1;

    always_comb
    begin
        state_next      = state_reg;
        left_next       = left_reg;
        right_next      = right_reg;
        count_next      = count_reg;
        front_next      = front_reg;
        back_next       = back_reg;
        pend_left_next  = pend_left_reg;
        out_valid_next  = out_valid_reg && out_stall;
        status_out_next = status_out_reg;
        count_out_next  = count_out_reg;
        front_out_next  = front_out_reg;
        back_out_next   = back_out_reg;
        mem_wr_en       = 1'b0;
        mem_wr_addr     = left_reg;
        mem_rd_en       = 1'b0;
        mem_rd_addr     = left_in_idx;
        load_out        = 1'b0;
        status_now      = cdeq_pkg::STATUS_DONE;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (is_push)
                    begin
                        load_out = 1'b1;
                        if (q_full)
                        begin
                            status_now = cdeq_pkg::STATUS_FULL;
                        end
                        else if (q_empty)
                        begin
                            // First word goes to the pushed end's slot; both ends meet there.
                            mem_wr_en   = 1'b1;
                            mem_wr_addr = is_left ? left_reg : right_reg;
                            left_next   = mem_wr_addr;
                            right_next  = mem_wr_addr;
                            count_next  = ONE_CNT;
                            front_next  = push_word;
                            back_next   = push_word;
                        end
                        else if (is_left)
                        begin
                            mem_wr_en   = 1'b1;
                            mem_wr_addr = left_out_idx;
                            left_next   = left_out_idx;
                            count_next  = count_reg + 1'b1;
                            front_next  = push_word;
                        end
                        else
                        begin
                            mem_wr_en   = 1'b1;
                            mem_wr_addr = right_out_idx;
                            right_next  = right_out_idx;
                            count_next  = count_reg + 1'b1;
                            back_next   = push_word;
                        end
                    end
                    else if (q_empty)
                    begin
                        load_out   = 1'b1;
                        status_now = cdeq_pkg::STATUS_EMPTY;
                    end
                    else
                    begin
                        count_next = count_reg - 1'b1;
                        if (is_left)
                        begin
                            left_next   = left_in_idx;
                            mem_rd_addr = left_in_idx;
                        end
                        else
                        begin
                            right_next  = right_in_idx;
                            mem_rd_addr = right_in_idx;
                        end
                        if (count_reg == ONE_CNT)
                        begin
                            load_out = 1'b1;
                        end
                        else
                        begin
                            // The new end word has to come from the store.
                            mem_rd_en      = 1'b1;
                            pend_left_next = is_left;
                            state_next     = S_FETCH;
                        end
                    end
                end
            end
            S_FETCH:
            begin
                if (pend_left_reg)
                begin
                    front_next = mem_rd_data;
                end
                else
                begin
                    back_next = mem_rd_data;
                end
                load_out   = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (load_out)
        begin
            out_valid_next  = 1'b1;
            status_out_next = status_now;
            count_out_next  = count_next;
            front_out_next  = (count_next == ZERO_CNT) ? '0 : front_next;
            back_out_next   = (count_next == ZERO_CNT) ? '0 : back_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            left_reg      <= '0;
            right_reg     <= '0;
            count_reg     <= '0;
            pend_left_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            left_reg      <= left_next;
            right_reg     <= right_next;
            count_reg     <= count_next;
            pend_left_reg <= pend_left_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // End words and the result payload need no reset.
    always_ff @(posedge clk)
    begin
        front_reg      <= front_next;
        back_reg       <= back_next;
        status_out_reg <= status_out_next;
        count_out_reg  <= count_out_next;
        front_out_reg  <= front_out_next;
        back_out_reg   <= back_out_next;
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_out_reg;
    assign count      = count_out_reg;
    assign is_empty   = (count_out_reg == ZERO_CNT);
    assign is_full    = (count_out_reg == FULL_CNT);
    assign front_word = front_out_reg;
    assign back_word  = back_out_reg;

    // The stored count never goes beyond the depth.
    a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("queue count beyond depth");

    // A pop that leaves words behind always goes through a fetch.
    a_pop_fetch : assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !is_push && (count_reg > ONE_CNT)) |=> (state_reg == S_FETCH))
        else $error("pop did not fetch the new end word");

    // During a fetch the output register is free and the input is held off.
    a_fetch_slot : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FETCH) |-> (!out_valid_reg && in_stall))
        else $error("fetch overlaps a pending result");

    // An empty queue reports zero end words.
    a_empty_zero : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && is_empty) |-> ((front_word == '0) && (back_word == '0)))
        else $error("empty result carries end words");

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the circular double-ended queue core.
`timescale 1ns / 100ps

module tb;

    localparam int DEPTH        = 16;
    localparam int CNT_W        = $clog2(DEPTH + 1);
    localparam int IDLE_LIMIT   = 2000;
    localparam int RANDOM_ITEMS = 1080;

    // The queue as seen on the result channel after one operation.
    typedef struct {
        cdeq_pkg::status_t status;
        logic [CNT_W-1:0]  count;
        logic              is_empty;
        logic              is_full;
        cdeq_pkg::word_t   front_word;
        cdeq_pkg::word_t   back_word;
    } deque_view_t;

    // Ways in which the receiver holds off result beats.
    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_style_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    cdeq_pkg::mode_t   mode = cdeq_pkg::MODE_PUSH_LEFT;
    cdeq_pkg::word_t   push_word = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    cdeq_pkg::status_t status;
    logic [CNT_W-1:0]  count;
    logic              is_empty;
    logic              is_full;
    cdeq_pkg::word_t   front_word;
    cdeq_pkg::word_t   back_word;

    // Words at the extremes of the signed range, plus zero and minus one.
    cdeq_pkg::word_t corner_words [4] = '{cdeq_pkg::word_t'(32'h8000_0000),
                                          cdeq_pkg::word_t'(32'h7fff_ffff),
                                          cdeq_pkg::word_t'(32'h0000_0000),
                                          cdeq_pkg::word_t'(32'hffff_ffff)};

    // Our own copy of the queue: slot contents, both inclusive end indexes and
    // the fill level. The indexes may drift apart while the queue is empty.
    cdeq_pkg::word_t slot_copy [DEPTH];
    int    left_at = 0;
    int    right_at = 0;
    int    fill = 0;

    // Views still owed by the block, oldest first.
    deque_view_t views_due [$];

    // Run statistics for the closing summary.
    int error_count = 0;
    int ops_accepted = 0;
    int results_seen = 0;
    int full_refusals = 0;
    int empty_refusals = 0;
    int drifted_reseeds = 0;
    int peak_fill = 0;
    int idle_cycles = 0;

    // Sender burst state and receiver stall state.
    int           burst_left = 0;
    stall_style_t stall_style = STALL_NONE;
    int           stall_phase_left = 0;
    int           tick = 0;

    circular_double_ended_queue_core #(.DEPTH(DEPTH)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .mode      (mode),
        .push_word (push_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .count     (count),
        .is_empty  (is_empty),
        .is_full   (is_full),
        .front_word(front_word),
        .back_word (back_word)
    );

    // 4 ns clock period, 2 ns high and 2 ns low.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // step_outward moves an index down the array, step_inward moves it up;
    // both wrap round the ends of the array.
    function automatic int step_outward(int idx);
        return (idx == 0) ? DEPTH - 1 : idx - 1;
    endfunction

    function automatic int step_inward(int idx);
        return (idx >= DEPTH - 1) ? 0 : idx + 1;
    endfunction

    // Applies one operation to our copy of the queue and returns the view
    // that the block must report for it.
    function automatic deque_view_t apply_deque_op(cdeq_pkg::mode_t op, cdeq_pkg::word_t word);
        deque_view_t view;
        view.status = cdeq_pkg::STATUS_DONE;
        if (op == cdeq_pkg::MODE_PUSH_LEFT || op == cdeq_pkg::MODE_PUSH_RIGHT)
        begin
            if (fill == DEPTH)
            begin
                view.status = cdeq_pkg::STATUS_FULL;
                full_refusals++;
            end
            else
            begin
                if (fill == 0)
                begin
                    // Pushing into an empty queue reseeds both ends at the
                    // current index of the end that is pushed.
                    if (left_at != right_at)
                        drifted_reseeds++;
                    if (op == cdeq_pkg::MODE_PUSH_LEFT)
                        right_at = left_at;
                    else
                        left_at = right_at;
                end
                else if (op == cdeq_pkg::MODE_PUSH_LEFT)
                    left_at = step_outward(left_at);
                else
                    right_at = step_inward(right_at);
                slot_copy[(op == cdeq_pkg::MODE_PUSH_LEFT) ? left_at : right_at] = word;
                fill++;
            end
        end
        else if (fill == 0)
        begin
            view.status = cdeq_pkg::STATUS_EMPTY;
            empty_refusals++;
        end
        else
        begin
            // A pop only moves the index; the slot keeps its old word.
            if (op == cdeq_pkg::MODE_POP_LEFT)
                left_at = step_inward(left_at);
            else
                right_at = step_outward(right_at);
            fill--;
        end
        if (fill > peak_fill)
            peak_fill = fill;
        view.count      = CNT_W'(fill);
        view.is_empty   = (fill == 0);
        view.is_full    = (fill == DEPTH);
        view.front_word = (fill == 0) ? cdeq_pkg::word_t'(0) : slot_copy[left_at];
        view.back_word  = (fill == 0) ? cdeq_pkg::word_t'(0) : slot_copy[right_at];
        return view;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch at result %0d: %s got %h want %h", results_seen, what, got, want);
        error_count++;
    endtask

    // Result checking, prediction and the watchdog share one process so that
    // a result beat is always matched before the operation accepted at the
    // same edge is queued. Every signal is read as it stood before the edge.
    always @(posedge clk)
    begin
        deque_view_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (views_due.size() == 0)
                    report_mismatch("result beat with none outstanding", 32'd0, 32'd0);
                else
                begin
                    want = views_due.pop_front();
                    if (status !== want.status)
                        report_mismatch("status", 32'(status), 32'(want.status));
                    if (count !== want.count)
                        report_mismatch("count", 32'(count), 32'(want.count));
                    if (is_empty !== want.is_empty)
                        report_mismatch("is_empty", 32'(is_empty), 32'(want.is_empty));
                    if (is_full !== want.is_full)
                        report_mismatch("is_full", 32'(is_full), 32'(want.is_full));
                    if (front_word !== want.front_word)
                        report_mismatch("front_word", front_word, want.front_word);
                    if (back_word !== want.back_word)
                        report_mismatch("back_word", back_word, want.back_word);
                end
            end
            if (in_valid && !in_stall)
            begin
                views_due.push_back(apply_deque_op(mode, push_word));
                ops_accepted++;
            end
            // The watchdog only looks for edges on which no beat moves at all.
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
            begin
                idle_cycles++;
                if (idle_cycles >= IDLE_LIMIT)
                begin
                    $display("watchdog: no beat accepted for %0d cycles", IDLE_LIMIT);
                    $display("tb: errors");
                    $finish;
                end
            end
        end
    end

    // The receiver picks a new stalling habit at random when each phase ends: no
    // stall at all, occasional stalls, mostly stalled, or a fixed pattern of
    // three stalled cycles in four.
    always @(posedge clk)
    begin
        if (stall_phase_left == 0)
        begin
            stall_style = stall_style_t'($urandom_range(0, 3));
            stall_phase_left = $urandom_range(40, 200);
        end
        else
            stall_phase_left--;
        tick++;
        case (stall_style)
            STALL_NONE:  out_stall <= 1'b0;
            STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: out_stall <= ($urandom_range(0, 9) < 7);
            default:     out_stall <= (tick % 4 != 0);
        endcase
    end

    // Sends one operation beat and waits for the edge where it is taken.
    // Between bursts the valid is dropped for a random gap; otherwise it
    // stays high so that the next beat follows without a bubble.
    task automatic send_op(cdeq_pkg::mode_t op, cdeq_pkg::word_t word);
        mode      <= op;
        push_word <= word;
        in_valid  <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 150)
                                                      : $urandom_range(0, 12);
        end
        else
            burst_left--;
    endtask

    // Mostly uniform words, with the corner words mixed in regularly.
    function automatic cdeq_pkg::word_t random_word();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 4)
            return corner_words[pick];
        return cdeq_pkg::word_t'($urandom);
    endfunction

    function automatic cdeq_pkg::mode_t random_op(int push_percent);
        bit on_left;
        on_left = $urandom_range(0, 1);
        if ($urandom_range(0, 99) < push_percent)
            return on_left ? cdeq_pkg::MODE_PUSH_LEFT : cdeq_pkg::MODE_PUSH_RIGHT;
        return on_left ? cdeq_pkg::MODE_POP_LEFT : cdeq_pkg::MODE_POP_RIGHT;
    endfunction

    // Pops from both ends of the freshly reset, empty queue must be refused.
    task automatic test_empty_pops();
        send_op(cdeq_pkg::MODE_POP_LEFT, corner_words[0]);
        send_op(cdeq_pkg::MODE_POP_RIGHT, corner_words[1]);
    endtask

    // Emptying the queue from the opposite end leaves the two indexes apart;
    // the next push, from either end, must bring them back onto one slot.
    task automatic test_index_drift();
        send_op(cdeq_pkg::MODE_PUSH_RIGHT, cdeq_pkg::word_t'(32'h1234_5678));
        send_op(cdeq_pkg::MODE_POP_LEFT, cdeq_pkg::word_t'(32'h0));
        send_op(cdeq_pkg::MODE_PUSH_RIGHT, corner_words[0]);
        send_op(cdeq_pkg::MODE_POP_RIGHT, cdeq_pkg::word_t'(32'h0));
        send_op(cdeq_pkg::MODE_PUSH_LEFT, corner_words[1]);
    endtask

    // Fill to the brim from alternate ends, so that the left index wraps round
    // the array, then try a push at each end of the full queue.
    task automatic test_fill_to_full();
        for (int k = 1; k < DEPTH; k++)
            send_op((k % 2 == 1) ? cdeq_pkg::MODE_PUSH_LEFT : cdeq_pkg::MODE_PUSH_RIGHT,
                    corner_words[k % 4]);
        send_op(cdeq_pkg::MODE_PUSH_LEFT, corner_words[2]);
        send_op(cdeq_pkg::MODE_PUSH_RIGHT, corner_words[3]);
    endtask

    // Random traffic in segments that lean towards filling, towards draining
    // or towards neither, so that the queue keeps swinging between empty and
    // full and the ends wrap many times.
    task automatic test_random_traffic();
        int sent;
        int segment;
        int push_percent;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 4))
                0:       push_percent = 85;
                1:       push_percent = 15;
                2:       push_percent = 60;
                3:       push_percent = 40;
                default: push_percent = 50;
            endcase
            segment = $urandom_range(20, 60);
            repeat (segment) send_op(random_op(push_percent), random_word());
            sent += segment;
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_pops();
        test_index_drift();
        test_fill_to_full();
        test_random_traffic();

        // Let every owed result drain, then keep watching so that a stray extra
        // beat can show itself.
        in_valid <= 1'b0;
        while (views_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("summary: %0d operations, %0d results, %0d refused when full, %0d when empty",
                 ops_accepted, results_seen, full_refusals, empty_refusals);
        $display("summary: peak fill %0d of %0d, %0d pushes reseeded drifted indexes",
                 peak_fill, DEPTH, drifted_reseeds);
        if (error_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
